// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/mm64_pkg.sv
// ----------------------------------------------------------------------------
// mm64_pkg
// Types, constants and helpers for the MurmurHash64A unit.
// ----------------------------------------------------------------------------
package mm64_pkg;

  localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
  localparam logic [31:0] MIX_LO    = MIX_MUL[31:0];
  localparam logic [31:0] MIX_HI    = MIX_MUL[63:32];
  localparam int unsigned MIX_SHIFT = 47;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    WK_NONE,
    WK_TAIL,
    WK_FULL
  } word_kind_t;

  typedef struct packed {
    logic [63:0] word;   // tail words already masked
    word_kind_t  kind;
    logic        first;
    logic        last;
    logic [31:0] total;
  } item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD,
    BK_SEED,
    BK_K1,
    BK_K2,
    BK_HM,
    BK_FM,
    BK_EMIT
  } bk_state_t;

  typedef struct packed {
    logic idle;
    logic emit;
  } bk_status_t;

  function automatic logic [63:0] xs47(input logic [63:0] x);
    return x ^ (x >> MIX_SHIFT);
  endfunction

endpackage

// File: rtl/core/mm64_if.sv
// ----------------------------------------------------------------------------
// mm64_if
// Request and result channels of the MurmurHash64A unit.
// ----------------------------------------------------------------------------
interface mm64_req_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  bytes_valid;
  logic        first_item;
  logic        last_item;
  logic [31:0] total_length;

  modport source (
    output valid, data_word, bytes_valid, first_item, last_item, total_length,
    input  ready
  );
  modport sink (
    input  valid, data_word, bytes_valid, first_item, last_item, total_length,
    output ready
  );
endinterface

interface mm64_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;
  logic        malformed;

  modport source (output valid, hash_value, malformed, input ready);
  modport sink (input valid, hash_value, malformed, output ready);
endinterface

// File: rtl/core/murmur64a_hash_64_unit.sv
// ----------------------------------------------------------------------------
// murmur64a_hash_64_unit
// Streaming MurmurHash64A over little-endian 64-bit words.
// ----------------------------------------------------------------------------
// Each request carries one message word; the request flagged last returns
// the finished hash and a malformed flag. A front stage masks and sorts the
// words into a two-entry queue, so requests keep flowing while the back end
// works. The back end runs every 64-bit multiply by the mix constant on one
// shared 32x32 multiplier, three partial products per multiply. A full word
// needs three multiplies, a partial word one and an empty word none; one
// more comes when a request starts a message and one more when it ends one.
// The seed may be written only while idle.
module murmur64a_hash_64_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data,
  mm64_req_if.sink    msg,
  mm64_res_if.source  result
);
  import mm64_pkg::*;
  `include "assert_macros.svh"

  logic        [63:0] hash_seed;
  logic               f_valid;
  item_t              f_item;
  logic               q_ready;
  logic               q_valid;
  item_t              q_item;
  logic               q_pop;
  bk_status_t         bk_st;
  logic        [63:0] bk_hash;
  logic               bk_bad;
  logic               res_valid;
  logic               out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_seed <= '0;
    end else if (cfg_wr_en) begin
      hash_seed <= cfg_wr_data;
    end
  end

  mm64_front u_front (
    .clk     (clk),
    .rst     (rst),
    .msg     (msg),
    .q_ready (q_ready),
    .f_valid (f_valid),
    .f_item  (f_item)
  );

  mm64_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid && q_ready),
    .push_item (f_item),
    .ready     (q_ready),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_item  (q_item)
  );

  mm64_back u_back (
    .clk      (clk),
    .rst      (rst),
    .seed     (hash_seed),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .out_free (out_free),
    .status   (bk_st),
    .fin_hash (bk_hash),
    .bad      (bk_bad)
  );

  // result register
  assign out_free     = !res_valid || result.ready;
  assign result.valid = res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (bk_st.emit) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (bk_st.emit) begin
      result.hash_value <= bk_hash;
      result.malformed  <= bk_bad;
    end
  end

  `ASSERT_IMPL(a_emit_free, clk, rst, bk_st.emit, !res_valid || result.ready, "result overwritten")
  `ASSERT_NEXT(a_emit_shows, clk, rst, bk_st.emit, result.valid && result.hash_value == $past(bk_hash), "result not presented")
  `ASSERT_IMPL(a_pop_idle, clk, rst, q_pop, bk_st.idle && q_valid, "queue popped while busy")

endmodule

// File: rtl/core/mm64_mul.sv
// ----------------------------------------------------------------------------
// mm64_mul
// Multiply by the mix constant mod 2^64, one 32x32 partial product a cycle.
// ----------------------------------------------------------------------------
module mm64_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] operand,
  output logic        done,
  output logic [63:0] result
);
  import mm64_pkg::*;

  logic [1:0]  step;
  logic [63:0] a_r;
  logic [63:0] acc;
  logic [31:0] ma;
  logic [31:0] mb;
  logic [63:0] prod;

  // step 0: lo*lo full, step 1: lo*hi upper half, step 2: hi*lo upper half
  always_comb begin
    case (step)
      2'd0:    ma = operand[31:0];
      2'd1:    ma = a_r[31:0];
      default: ma = a_r[63:32];
    endcase
    mb   = (step == 2'd1) ? MIX_HI : MIX_LO;
    prod = 64'(ma) * 64'(mb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 2'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (step)
        2'd0: if (start) step <= 2'd1;
        2'd1: step <= 2'd2;
        2'd2: begin
          step <= 2'd0;
          done <= 1'b1;
        end
        default: step <= 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (step == 2'd0) begin
      if (start) begin
        a_r <= operand;
        acc <= prod;
      end
    end else begin
      acc[63:32] <= acc[63:32] + prod[31:0];
    end
  end

  assign result = acc;

endmodule

// File: rtl/core/mm64_queue.sv
// ----------------------------------------------------------------------------
// mm64_queue
// Short FIFO of classified words between front and back.
// ----------------------------------------------------------------------------
module mm64_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mm64_pkg::item_t push_item,
  output logic            ready,
  input  logic            pop,
  output logic            valid,
  output mm64_pkg::item_t pop_item
);
  import mm64_pkg::*;

  item_t               slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign ready    = (count != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign valid    = (count != '0);
  assign pop_item = slots[rd_ptr];

  function automatic logic [QUEUE_AW-1:0] bump(input logic [QUEUE_AW-1:0] p);
    return (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

endmodule

// File: rtl/core/mm64_front.sv
// ----------------------------------------------------------------------------
// mm64_front
// Takes requests, sorts each word as full, tail or empty and masks tails.
// ----------------------------------------------------------------------------
module mm64_front (
  input  logic            clk,
  input  logic            rst,
  mm64_req_if.sink        msg,
  input  logic            q_ready,
  output logic            f_valid,
  output mm64_pkg::item_t f_item
);
  import mm64_pkg::*;

  item_t       cls;
  logic [63:0] tail_mask;

  assign msg.ready = !f_valid || q_ready;

  always_comb begin
    tail_mask = ~(64'hFFFF_FFFF_FFFF_FFFF << {msg.bytes_valid[2:0], 3'b000});
    cls.first = msg.first_item;
    cls.last  = msg.last_item;
    cls.total = msg.total_length;
    // counts of eight or more count as a full word
    if (msg.bytes_valid[3]) begin
      cls.kind = WK_FULL;
      cls.word = msg.data_word;
    end else if (msg.bytes_valid[2:0] == 3'd0) begin
      cls.kind = WK_NONE;
      cls.word = msg.data_word;
    end else begin
      cls.kind = WK_TAIL;
      cls.word = msg.data_word & tail_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (msg.ready) begin
      f_valid <= msg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (msg.valid && msg.ready) f_item <= cls;
  end

endmodule

// File: rtl/core/mm64_back.sv
// ----------------------------------------------------------------------------
// mm64_back
// Sequencer that runs the word mix, hash update and finish on one multiplier.
// ----------------------------------------------------------------------------
module mm64_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [63:0]          seed,
  input  logic                 q_valid,
  input  mm64_pkg::item_t      q_item,
  output logic                 q_pop,
  input  logic                 out_free,
  output mm64_pkg::bk_status_t status,
  output logic [63:0]          fin_hash,
  output logic                 bad
);
  import mm64_pkg::*;

  bk_state_t   state;
  bk_state_t   state_next;
  item_t       cur;
  logic [63:0] h;
  logic [63:0] h_cur;
  logic        bad_next;
  logic        mul_start;
  logic [63:0] mul_op;
  logic        mul_done;
  logic [63:0] mul_res;
  logic        fin_load;
  logic        word_go;
  logic        fin_go;
  bk_state_t   word_dst;

  mm64_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .operand (mul_op),
    .done    (mul_done),
    .result  (mul_res)
  );

  // hash as it stands after this cycle's update
  always_comb begin
    h_cur = h;
    if (state == BK_SEED && mul_done) h_cur = seed ^ mul_res;
    if (state == BK_HM && mul_done)   h_cur = mul_res;
  end

  assign word_go = (state == BK_LOAD && !cur.first) || (state == BK_SEED && mul_done);
  assign fin_go  = (word_go && cur.kind == WK_NONE) || (state == BK_HM && mul_done);

  always_comb begin
    case (cur.kind)
      WK_FULL: word_dst = BK_K1;
      WK_TAIL: word_dst = BK_HM;
      default: word_dst = cur.last ? BK_FM : BK_IDLE;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (q_valid) state_next = BK_LOAD;
      BK_LOAD: state_next = cur.first ? BK_SEED : word_dst;
      BK_SEED: if (mul_done) state_next = word_dst;
      BK_K1:   if (mul_done) state_next = BK_K2;
      BK_K2:   if (mul_done) state_next = BK_HM;
      BK_HM:   if (mul_done) state_next = cur.last ? BK_FM : BK_IDLE;
      BK_FM:   if (mul_done) state_next = BK_EMIT;
      BK_EMIT: if (out_free) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop       = 1'b0;
    mul_start   = 1'b0;
    mul_op      = cur.word;
    fin_load    = 1'b0;
    status.emit = 1'b0;
    status.idle = (state == BK_IDLE);
    bad_next    = bad;
    unique case (state)
      BK_IDLE: q_pop = q_valid;
      BK_LOAD: begin
        if (cur.first) begin
          mul_start = 1'b1;
          mul_op    = {32'd0, cur.total};
        end
      end
      BK_SEED: if (mul_done) bad_next = 1'b0;
      BK_K1: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_op    = xs47(mul_res);
        end
      end
      BK_K2: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_op    = h ^ mul_res;
        end
      end
      BK_HM: if (mul_done && cur.kind == WK_TAIL && !cur.last) bad_next = 1'b1;
      BK_FM:   fin_load = mul_done;
      BK_EMIT: status.emit = out_free;
      default: ;
    endcase
    if (word_go && cur.kind == WK_FULL) begin
      mul_start = 1'b1;
      mul_op    = cur.word;
    end else if (word_go && cur.kind == WK_TAIL) begin
      mul_start = 1'b1;
      mul_op    = h_cur ^ cur.word;
    end
    if (fin_go && cur.last) begin
      mul_start = 1'b1;
      mul_op    = xs47(h_cur);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      h     <= '0;
      bad   <= 1'b0;
    end else begin
      state <= state_next;
      h     <= h_cur;
      bad   <= bad_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop)    cur      <= q_item;
    if (fin_load) fin_hash <= xs47(mul_res);
  end

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for murmur64a_hash_64_unit. A short table of directed
// requests is followed by random messages over several seed settings, with
// random gaps and stalls on both channels. Every accepted request goes
// through a local MurmurHash64A model, and each returned hash is compared
// with the oldest expected one.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mm64_pkg::*;

  localparam logic [3:0] FULL_BYTES   = 4'd8;
  localparam int         WORDS_TARGET = 850;
  localparam int         SEED_PHASES  = 6;
  localparam int         SETTLE_LAT   = 80;   // several worst-case requests
  localparam int         HOLD_CYCLES  = 300;

  typedef struct packed {
    bit [63:0] word;
    bit [3:0]  nbytes;
    bit        first;
    bit        last;
    bit [31:0] total;
  } req_t;

  typedef struct packed {
    bit [63:0] hash;
    bit        bad;
  } digest_t;

  typedef struct packed {
    req_t    req;
    bit      typed;
    digest_t typed_val;
  } plan_row_t;

  localparam int PLAN_ROWS = 23;
  localparam bit [63:0] ONES = 64'hffff_ffff_ffff_ffff;

  // rows marked typed carry their hash; all others are predicted
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // empty message on seed 0 hashes to 0
    '{'{ONES,                  4'd0,  1'b1, 1'b1, 32'h0},        1'b1, '{64'h0, 1'b0}},
    // no start flag, hash still 0 from above
    '{'{64'h0123_4567_89ab_cdef, 4'd0,  1'b0, 1'b1, 32'hffff_ffff}, 1'b1, '{64'h0, 1'b0}},
    '{'{ONES,                  4'd8,  1'b1, 1'b0, 32'hffff_ffff}, 1'b0, '{64'h0, 1'b0}},
    '{'{64'h0,                 4'd8,  1'b0, 1'b0, 32'h0},        1'b0, '{64'h0, 1'b0}},
    '{'{64'h0123_4567_89ab_cdef, 4'd15, 1'b0, 1'b0, 32'h0},        1'b0, '{64'h0, 1'b0}},
    '{'{64'hfedc_ba98_7654_3210, 4'd9,  1'b0, 1'b0, 32'h0},        1'b0, '{64'h0, 1'b0}},
    // partial word ahead of the end taints the message
    '{'{ONES,                  4'd3,  1'b0, 1'b0, 32'h0},        1'b0, '{64'h0, 1'b0}},
    '{'{64'h8000_0000_0000_0001, 4'd8,  1'b0, 1'b1, 32'h0},        1'b0, '{64'h0, 1'b0}},
    '{'{64'h0,                 4'd0,  1'b0, 1'b1, 32'h0},        1'b0, '{64'h0, 1'b0}},
    '{'{64'h5555_5555_5555_5555, 4'd1,  1'b1, 1'b1, 32'd1},        1'b0, '{64'h0, 1'b0}},
    '{'{64'haaaa_aaaa_aaaa_aaaa, 4'd2,  1'b1, 1'b1, 32'd2},        1'b0, '{64'h0, 1'b0}},
    '{'{ONES,                  4'd3,  1'b1, 1'b1, 32'd3},        1'b0, '{64'h0, 1'b0}},
    '{'{ONES,                  4'd4,  1'b1, 1'b1, 32'd4},        1'b0, '{64'h0, 1'b0}},
    '{'{ONES,                  4'd5,  1'b1, 1'b1, 32'd5},        1'b0, '{64'h0, 1'b0}},
    '{'{ONES,                  4'd6,  1'b1, 1'b1, 32'd6},        1'b0, '{64'h0, 1'b0}},
    '{'{ONES,                  4'd7,  1'b1, 1'b1, 32'd7},        1'b0, '{64'h0, 1'b0}},
    '{'{ONES,                  4'd8,  1'b1, 1'b1, 32'd8},        1'b0, '{64'h0, 1'b0}},
    '{'{64'h0,                 4'd8,  1'b1, 1'b1, 32'd0},        1'b0, '{64'h0, 1'b0}},
    '{'{64'h1234_5678_9abc_def0, 4'd8,  1'b1, 1'b0, 32'd15},       1'b0, '{64'h0, 1'b0}},
    '{'{64'hdead_beef_cafe_f00d, 4'd7,  1'b0, 1'b1, 32'd15},       1'b0, '{64'h0, 1'b0}},
    '{'{64'h0,                 4'd10, 1'b1, 1'b1, 32'hffff_ffff}, 1'b0, '{64'h0, 1'b0}},
    '{'{ONES,                  4'd0,  1'b1, 1'b0, 32'h0},        1'b0, '{64'h0, 1'b0}},
    '{'{ONES,                  4'd8,  1'b0, 1'b1, 32'h0},        1'b0, '{64'h0, 1'b0}}
  };

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [63:0] cfg_wr_data;

  mm64_req_if msg ();
  mm64_res_if result ();

  murmur64a_hash_64_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .msg         (msg),
    .result      (result)
  );

  // model state
  bit [63:0] seed_shadow;
  bit [63:0] acc_hash;
  bit        tainted;

  digest_t   due_hashes[$];
  int        words_sent;
  int        errors;
  bit        sender_fast;
  bit        sink_fast;
  bit        hold_request;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400us;
    $display("testbench: done, errors");
    $finish;
  end

  function automatic word_kind_t classify(bit [3:0] n);
    if (n == 4'd0) return WK_NONE;
    if (n >= FULL_BYTES) return WK_FULL;
    return WK_TAIL;
  endfunction

  function automatic bit [63:0] scramble(bit [63:0] k);
    k = k * MIX_MUL;
    k = k ^ (k >> MIX_SHIFT);
    return k * MIX_MUL;
  endfunction

  function automatic bit [63:0] finalize(bit [63:0] h);
    h = h ^ (h >> MIX_SHIFT);
    h = h * MIX_MUL;
    return h ^ (h >> MIX_SHIFT);
  endfunction

  // advances the model by one request; returns 1 when a hash comes out
  function automatic bit absorb_word(input req_t r, output digest_t d);
    bit [63:0] keep;
    keep = ~(ONES << {r.nbytes[2:0], 3'b000});
    if (r.first) begin
      acc_hash = seed_shadow ^ (64'(r.total) * MIX_MUL);
      tainted  = 1'b0;
    end
    case (classify(r.nbytes))
      WK_FULL: acc_hash = (acc_hash ^ scramble(r.word)) * MIX_MUL;
      WK_TAIL: begin
        acc_hash = (acc_hash ^ (r.word & keep)) * MIX_MUL;
        if (!r.last) tainted = 1'b1;
      end
      default: ;
    endcase
    d.hash = finalize(acc_hash);
    d.bad  = tainted;
    return r.last;
  endfunction

  task automatic send_req(input req_t r, input bit typed, input digest_t typed_val);
    int      gap;
    digest_t d;
    if ($urandom_range(0, 39) == 0) sender_fast = !sender_fast;
    gap = sender_fast ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      msg.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg.valid        <= 1'b1;
    msg.data_word    <= r.word;
    msg.bytes_valid  <= r.nbytes;
    msg.first_item   <= r.first;
    msg.last_item    <= r.last;
    msg.total_length <= r.total;
    do @(posedge clk); while (!msg.ready);
    if (absorb_word(r, d)) due_hashes.push_back(typed ? typed_val : d);
    words_sent++;
  endtask

  task automatic write_seed(input bit [63:0] value);
    msg.valid <= 1'b0;
    while (due_hashes.size() != 0) @(posedge clk);
    // requests that end no message may still be in flight
    repeat (SETTLE_LAT) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    seed_shadow = value;
  endtask

  task automatic send_message();
    int      len;
    int      nwords;
    int      rem;
    bit      broken;
    bit [31:0] claimed;
    req_t    r;
    digest_t none;
    none   = '0;
    len    = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120) : $urandom_range(0, 40);
    nwords = (len + 7) / 8;
    if (nwords == 0) nwords = 1;
    claimed = ($urandom_range(0, 7) == 0) ? $urandom() : len;
    broken  = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < nwords; i++) begin
      rem      = len - 8 * i;
      r.word   = {$urandom(), $urandom()};
      r.first  = (i == 0);
      r.last   = (i == nwords - 1);
      r.total  = claimed;
      r.nbytes = (rem >= 8) ? FULL_BYTES : 4'(rem);
      if (r.nbytes == FULL_BYTES && $urandom_range(0, 19) == 0)
        r.nbytes = 4'($urandom_range(9, 15));
      if (broken && r.first && $urandom_range(0, 1) == 0) r.first = 1'b0;
      if (broken && !r.last && $urandom_range(0, 2) == 0)
        r.nbytes = 4'($urandom_range(1, 7));
      send_req(r, 1'b0, none);
    end
  endtask

  task automatic send_noise();
    req_t    r;
    digest_t none;
    none     = '0;
    r.word   = {$urandom(), $urandom()};
    r.nbytes = 4'($urandom_range(0, 15));
    r.first  = 1'($urandom_range(0, 1));
    r.last   = 1'($urandom_range(0, 1));
    r.total  = $urandom();
    send_req(r, 1'b0, none);
  endtask

  initial begin : result_sink
    int      stall;
    digest_t want;
    result.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) sink_fast = !sink_fast;
      stall = sink_fast ? 0 : $urandom_range(0, 8);
      if (hold_request) begin
        stall        = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (stall > 0) begin
        result.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result.ready <= 1'b1;
      do @(posedge clk); while (!result.valid);
      if (due_hashes.size() == 0) begin
        $error("unexpected result: hash_value %h malformed %0d",
               result.hash_value, result.malformed);
        errors++;
      end else begin
        want = due_hashes.pop_front();
        if (result.hash_value !== want.hash) begin
          $error("hash_value: expected %h, got %h", want.hash, result.hash_value);
          errors++;
        end
        if (result.malformed !== want.bad) begin
          $error("malformed: expected %0d, got %0d", want.bad, result.malformed);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    bit [63:0] seeds [SEED_PHASES];
    req_t      r;
    rst              <= 1'b1;
    cfg_wr_en        <= 1'b0;
    cfg_wr_data      <= '0;
    msg.valid        <= 1'b0;
    msg.data_word    <= '0;
    msg.bytes_valid  <= '0;
    msg.first_item   <= 1'b0;
    msg.last_item    <= 1'b0;
    msg.total_length <= '0;
    seed_shadow  = '0;
    acc_hash     = '0;
    tainted      = 1'b0;
    hold_request = 1'b0;
    seeds = '{ONES, 64'h0, {$urandom(), $urandom()}, 64'h1,
              64'h8000_0000_0000_0000, {$urandom(), $urandom()}};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (PLAN[i]) begin
      r = PLAN[i].req;
      send_req(r, PLAN[i].typed, PLAN[i].typed_val);
    end

    for (int p = 0; p < SEED_PHASES; p++) begin
      write_seed(seeds[p]);
      // a long sink stall here backs the block up into the request side
      if (p == 2) hold_request = 1'b1;
      while (words_sent < PLAN_ROWS + (p + 1) * WORDS_TARGET / SEED_PHASES) begin
        if ($urandom_range(0, 6) == 0) send_noise();
        else send_message();
      end
    end

    msg.valid <= 1'b0;
    while (due_hashes.size() != 0) @(posedge clk);
    repeat (SETTLE_LAT) @(posedge clk);
    if (errors == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
